[rtl/gbp_pkg.sv]
`default_nettype none
// ============================================================================
// gbp_pkg
// Shared constants, register codes and record types of the glyph blitter.
// ============================================================================
package gbp_pkg;

    // Screen geometry and glyph limits
    localparam int SCREEN_WIDTH     = 1404;
    localparam int SCREEN_HEIGHT    = 1872;
    localparam int ROW_STRIDE_BYTES = 1408;
    localparam int TOP_MARGIN       = 8;
    localparam int SIDE_MARGIN      = 8;
    localparam int MAX_GLYPH_SIZE   = 256;
    localparam int GLYPH_CAP        = (MAX_GLYPH_SIZE < 256) ? MAX_GLYPH_SIZE : 256;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 22;
    localparam int WORD_W     = 16;
    localparam int OFF_W      = 13;
    localparam int SIZE_W     = 9;
    localparam int INK_W      = 2;
    localparam int FLEN_W     = 23;
    localparam int CNT_W      = 8;
    localparam int FRAME_CAP  = 4194304;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Segment record widths
    localparam int YW = $clog2(SCREEN_HEIGHT + 1);
    localparam int XW = $clog2(SCREEN_WIDTH + 1);

    // Queue between front and back
    localparam int Q_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ORG    = 3'd0,
        REG_Y_ORG    = 3'd1,
        REG_WIDTH    = 3'd2,
        REG_HEIGHT   = 3'd3,
        REG_INK      = 3'd4,
        REG_FLEN     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [OFF_W-1:0] x_org;
        logic signed [OFF_W-1:0] y_org;
        logic [SIZE_W-1:0]       width;
        logic [SIZE_W-1:0]       height;
        logic [INK_W-1:0]        ink;
        logic [FLEN_W-1:0]       flen;
    } cfg_t;

    // One closed word segment, ready for address generation
    typedef struct packed {
        logic [YW-1:0]     y;
        logic [XW-1:0]     x;
        logic [FLEN_W-1:0] flen;
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] mask;
        logic              done;
    } seg_rec_t;

endpackage
`default_nettype wire

[rtl/gbp_pix_if.sv]
`default_nettype none
// ============================================================================
// gbp_pix_if
// Glyph bitmap byte stream, one byte per beat.
// ============================================================================
interface gbp_pix_if
    import gbp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] glyph_byte;

    modport source (output valid, output glyph_byte, input ready);
    modport sink   (input valid, input glyph_byte, output ready);
endinterface
`default_nettype wire

[rtl/gbp_wr_if.sv]
`default_nettype none
// ============================================================================
// gbp_wr_if
// Masked framebuffer word writes, one write per beat.
// ============================================================================
interface gbp_wr_if
    import gbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] word_address;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] bit_mask;
    logic              last_in_run;
    logic              glyph_done;

    modport source (output valid, output word_address, output write_data,
                    output bit_mask, output last_in_run, output glyph_done,
                    input ready);
    modport sink   (input valid, input word_address, input write_data,
                    input bit_mask, input last_in_run, input glyph_done,
                    output ready);
endinterface
`default_nettype wire

[rtl/gbp_cfg_if.sv]
`default_nettype none
// ============================================================================
// gbp_cfg_if
// Configuration write channel: register index and data per beat.
// ============================================================================
interface gbp_cfg_if
    import gbp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/gbp_front.sv]
`default_nettype none
// ============================================================================
// gbp_front
// Accepts glyph bytes, counts column and row, clips, and merges the set
// pixels of each word segment into data and mask.
// ============================================================================
module gbp_front
    import gbp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    gbp_pix_if.sink   pixels,
    input  wire logic q_full,
    output logic      push,
    output seg_rec_t  push_rec
);

    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic              open_reg, open_next;
    logic [YW-1:0]     seg_y_reg, seg_y_next;
    logic [XW-1:0]     seg_x_reg, seg_x_next;
    logic [FLEN_W-1:0] seg_flen_reg, seg_flen_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic [WORD_W-1:0] mask_reg, mask_next;

    logic              accept;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic              last_col, last_row;
    logic signed [OFF_W:0] ypos, bx;
    logic [2:0]        pos;
    logic [3:0]        sh;
    logic              row_ok, col_ok, open_now, seg_active, seg_close;
    logic [WORD_W-1:0] data_base, mask_base, data_new, mask_new;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > SIZE_W'(GLYPH_CAP))
            r = SIZE_W'(GLYPH_CAP);
        else
            r = v;
        return r;
    endfunction

    assign pixels.ready = !q_full;
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        w_eff    = eff_size(cfg.width);
        h_eff    = eff_size(cfg.height);
        last_col = ({1'b0, col_reg} + SIZE_W'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + SIZE_W'(1)) >= h_eff;
        ypos     = $signed({{(OFF_W+1-CNT_W){1'b0}}, row_reg}) + {cfg.y_org[OFF_W-1], cfg.y_org};
        bx       = $signed({{(OFF_W+1-CNT_W){1'b0}}, col_reg}) + {cfg.x_org[OFF_W-1], cfg.x_org};
        pos      = bx[2:0];
        sh       = {~pos, 1'b0};
        row_ok   = (ypos >= $signed((OFF_W+1)'(0))) &&
                   (ypos <  $signed((OFF_W+1)'(SCREEN_HEIGHT)));
        col_ok   = (bx >= $signed((OFF_W+1)'(SIDE_MARGIN))) &&
                   (bx <  $signed((OFF_W+1)'(SCREEN_WIDTH)));
        open_now   = !open_reg && row_ok && col_ok;
        seg_active = open_reg || open_now;
        seg_close  = seg_active && ((pos == 3'd7) || last_col);

        data_base = open_now ? '0 : data_reg;
        mask_base = open_now ? '0 : mask_reg;
        data_new  = data_base;
        mask_new  = mask_base;
        if (pixels.glyph_byte != '0)
        begin
            data_new = data_base | (WORD_W'(cfg.ink) << sh);
            mask_new = mask_base | (WORD_W'(2'b11) << sh);
        end

        // Capture geometry at segment open; hold it otherwise
        seg_y_next    = open_now ? ypos[YW-1:0] : seg_y_reg;
        seg_x_next    = open_now ? bx[XW-1:0]   : seg_x_reg;
        seg_flen_next = open_now ? cfg.flen     : seg_flen_reg;

        col_next  = col_reg;
        row_next  = row_reg;
        open_next = open_reg;
        data_next = data_reg;
        mask_next = mask_reg;
        if (accept)
        begin
            open_next = seg_active && !seg_close;
            if (seg_active)
            begin
                data_next = data_new;
                mask_next = mask_new;
            end
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : CNT_W'(row_reg + CNT_W'(1));
            end
            else
            begin
                col_next = CNT_W'(col_reg + CNT_W'(1));
            end
        end

        // Drop empty segments here; the frame limit is checked at the back
        push          = accept && seg_close && (mask_new != '0);
        push_rec.y    = seg_y_next;
        push_rec.x    = seg_x_next;
        push_rec.flen = seg_flen_next;
        push_rec.data = data_new;
        push_rec.mask = mask_new;
        push_rec.done = last_col && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            open_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seg_y_reg    <= seg_y_next;
            seg_x_reg    <= seg_x_next;
            seg_flen_reg <= seg_flen_next;
            data_reg     <= data_next;
            mask_reg     <= mask_next;
        end
    end

endmodule
`default_nettype wire

[rtl/gbp_queue.sv]
`default_nettype none
// ============================================================================
// gbp_queue
// Short record queue that decouples the front from the back.
// ============================================================================
module gbp_queue
    import gbp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire seg_rec_t push_rec,
    output logic          full,
    input  wire logic     pop,
    output logic          head_vld,
    output seg_rec_t      head_rec
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W  = $clog2(Q_DEPTH + 1);

    seg_rec_t         mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]  count_reg, count_next;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(p + PTR_W'(1));
    endfunction

    assign full     = (count_reg == QC_W'(Q_DEPTH));
    assign head_vld = (count_reg != '0);
    assign head_rec = mem[rd_ptr_reg];
    assign do_pop   = pop && head_vld;

    always_comb
    begin
        wr_ptr_next = push   ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = QC_W'(count_reg + QC_W'(1));
        else if (!push && do_pop)
            count_next = QC_W'(count_reg - QC_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_rec;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QC_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == QC_W'($past(count_reg) + QC_W'(1))))
        else $error("queue count did not advance on push");

endmodule
`default_nettype wire

[rtl/gbp_back.sv]
`default_nettype none
// ============================================================================
// gbp_back
// Turns queued segments into word addresses, drops words past the frame
// and holds the write in the output register.
// ============================================================================
module gbp_back
    import gbp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     head_vld,
    input  wire seg_rec_t head_rec,
    output logic          pop,
    gbp_wr_if.source      writes
);

    localparam int ROW_BASE = TOP_MARGIN + SCREEN_HEIGHT - 1;
    localparam int RB_W     = $clog2(ROW_BASE + 1) + 1;
    localparam int PROD_W   = $clog2(ROW_BASE * ROW_STRIDE_BYTES + 1) + 1;
    localparam int CS_W     = $clog2(SIDE_MARGIN + SCREEN_WIDTH) + 1;
    localparam int FULL_W   = ((PROD_W > CS_W) ? PROD_W : CS_W) + 1;
    localparam int CMP_W    = ((FULL_W > FLEN_W) ? FULL_W : FLEN_W) + 1;

    // Stage A: row and column terms
    logic              a_vld_reg, a_vld_next;
    logic [PROD_W-1:0] a_row_reg;
    logic [CS_W-1:0]   a_col_reg;
    logic [FLEN_W-1:0] a_flen_reg;
    logic [WORD_W-1:0] a_data_reg, a_mask_reg;
    logic              a_done_reg;

    // Stage B: output register
    logic              out_vld_reg, out_vld_next;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [WORD_W-1:0] out_data_reg, out_mask_reg;
    logic              out_done_reg;

    logic              b_load, a_take;
    logic [RB_W-1:0]   row_idx;
    logic [CS_W-1:0]   col_sum, col_term;
    logic [FLEN_W-1:0] flen_cap;
    logic [FULL_W-1:0] addr_full;
    logic              drawable;

    always_comb
    begin
        b_load = !out_vld_reg || writes.ready;
        a_take = !a_vld_reg || b_load;
        pop    = head_vld && a_take;

        row_idx  = RB_W'(ROW_BASE) - RB_W'(head_rec.y);
        col_sum  = CS_W'(SIDE_MARGIN) + CS_W'(head_rec.x);
        col_term = CS_W'({col_sum[CS_W-1:3], 1'b0});
        flen_cap = (head_rec.flen > FLEN_W'(FRAME_CAP)) ? FLEN_W'(FRAME_CAP) : head_rec.flen;

        addr_full = FULL_W'(a_row_reg) + FULL_W'(a_col_reg);
        drawable  = (CMP_W'(addr_full) + CMP_W'(1)) < CMP_W'(a_flen_reg);

        a_vld_next   = a_take ? head_vld : a_vld_reg;
        out_vld_next = b_load ? (a_vld_reg && drawable) : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg   <= a_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_row_reg  <= PROD_W'(row_idx) * PROD_W'(ROW_STRIDE_BYTES);
            a_col_reg  <= col_term;
            a_flen_reg <= flen_cap;
            a_data_reg <= head_rec.data;
            a_mask_reg <= head_rec.mask;
            a_done_reg <= head_rec.done;
        end
        if (b_load && a_vld_reg)
        begin
            out_addr_reg <= ADDR_W'(addr_full);
            out_data_reg <= a_data_reg;
            out_mask_reg <= a_mask_reg;
            out_done_reg <= a_done_reg;
        end
    end

    assign writes.valid        = out_vld_reg;
    assign writes.word_address = out_addr_reg;
    assign writes.write_data   = out_data_reg;
    assign writes.bit_mask     = out_mask_reg;
    assign writes.last_in_run  = 1'b1;
    assign writes.glyph_done   = out_done_reg;

    a_mask_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_mask_reg != '0))
        else $error("write issued with empty mask");

    a_data_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ((out_data_reg & ~out_mask_reg) == '0))
        else $error("write data outside mask");

endmodule
`default_nettype wire

[rtl/glyph_blit_packed_2bpp_unit.sv]
`default_nettype none
// ============================================================================
// glyph_blit_packed_2bpp_unit
// Glyph blitter into a 2-bit-per-pixel packed framebuffer.
// ============================================================================
// Feed glyph bitmap bytes in raster order, one per beat; the block counts
// column and row itself and wraps to a new glyph after the last byte. It
// takes a new byte on every beat while the write side keeps up. Every
// closed word segment with at least one drawn pixel inside the frame
// yields one masked 16-bit write, at most one per input beat. The write
// passes through the queue entry, the address stage and the output
// register before it is offered, and the write side can hold it in the
// output register until it raises ready. The input stalls only when the
// four-entry segment queue is full, which happens when the write side
// holds ready low. Configuration writes are accepted in any cycle; write
// them while the block is idle.
// ============================================================================
module glyph_blit_packed_2bpp_unit
    import gbp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    gbp_cfg_if.sink   cfg,
    gbp_pix_if.sink   pixels,
    gbp_wr_if.source  writes
);

    cfg_t     cfg_reg, cfg_next;
    logic     q_push, q_full, q_pop, q_head_vld;
    seg_rec_t q_push_rec, q_head_rec;

    // Register file: accept every beat, drop indexes past the list
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_X_ORG:    cfg_next.x_org    = $signed(cfg.data[OFF_W-1:0]);
                REG_Y_ORG:    cfg_next.y_org    = $signed(cfg.data[OFF_W-1:0]);
                REG_WIDTH:    cfg_next.width    = cfg.data[SIZE_W-1:0];
                REG_HEIGHT:   cfg_next.height   = cfg.data[SIZE_W-1:0];
                REG_INK:      cfg_next.ink      = cfg.data[INK_W-1:0];
                REG_FLEN:     cfg_next.flen     = cfg.data[FLEN_W-1:0];
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_org    <= '0;
            cfg_reg.y_org    <= '0;
            cfg_reg.width    <= SIZE_W'(1);
            cfg_reg.height   <= SIZE_W'(1);
            cfg_reg.ink      <= '0;
            cfg_reg.flen     <= FLEN_W'(FRAME_CAP);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: count, clip and merge pixels into word segments
    gbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .pixels   (pixels),
        .q_full   (q_full),
        .push     (q_push),
        .push_rec (q_push_rec)
    );

    // Queue: hold closed segments while the write side stalls
    gbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .head_vld (q_head_vld),
        .head_rec (q_head_rec)
    );

    // Back: form the byte address, drop words past the frame, issue writes
    gbp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_vld (q_head_vld),
        .head_rec (q_head_rec),
        .pop      (q_pop),
        .writes   (writes)
    );

endmodule
`default_nettype wire

[verif/glyph_blit_packed_2bpp_unit_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// glyph_blit_packed_2bpp_unit_tb
// Self-checking bench for the 2bpp glyph blitter. A scoreboard class walks
// the glyph raster alongside the block, predicts every masked word write
// and compares each write beat against the oldest prediction. Directed
// glyphs cover clipping, flip, frame limit and size corner cases; random
// glyphs with random register settings follow, under bursty input and a
// stalling write side.
// ============================================================================
module glyph_blit_packed_2bpp_unit_tb;
    import gbp_pkg::*;

    // One masked framebuffer write as it appears on the write channel
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] mask;
        logic              last;
        logic              done;
    } fb_write_t;

    // ------------------------------------------------------------------------
    // Scoreboard: raster walk, segment merge and the queue of due writes
    // ------------------------------------------------------------------------
    class word_write_board;
        int x_off, y_off, width, height, ink, flen;
        int col, row;
        logic [ADDR_W-1:0] seg_addr;
        logic [WORD_W-1:0] seg_data, seg_mask;
        bit seg_open, seg_live;
        fb_write_t due_writes[$];
        int fails;

        function new();
            x_off = 0;
            y_off = 0;
            width = 1;
            height = 1;
            ink = 0;
            flen = FRAME_CAP;
            col = 0;
            row = 0;
            seg_addr = '0;
            seg_data = '0;
            seg_mask = '0;
            seg_open = 0;
            seg_live = 0;
            fails = 0;
        endfunction

        function int fit_size(int v);
            if (v == 0)
                return 1;
            return (v > GLYPH_CAP) ? GLYPH_CAP : v;
        endfunction

        function void note_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_X_ORG:    x_off = int'($signed(value[OFF_W-1:0]));
                REG_Y_ORG:    y_off = int'($signed(value[OFF_W-1:0]));
                REG_WIDTH:    width = int'(value[SIZE_W-1:0]);
                REG_HEIGHT:   height = int'(value[SIZE_W-1:0]);
                REG_INK:      ink = int'(value[INK_W-1:0]);
                REG_FLEN:     flen = int'(value[FLEN_W-1:0]);
                default:      ;
            endcase
        endfunction

        // Advance the raster by one glyph byte and queue the write it closes
        function void note_pixel(logic [PIX_W-1:0] pix);
            int w, h, ypos, bx, pos, brow, addr, cap, shift;
            bit col_end, row_end;
            fb_write_t wr;
            w = fit_size(width);
            h = fit_size(height);
            col_end = (col + 1 >= w);
            row_end = (row + 1 >= h);
            ypos = row + y_off;
            bx = col + x_off;
            pos = bx & 7;
            // right edge only gates the opening pixel of a segment
            if (!seg_open && ypos >= 0 && ypos < SCREEN_HEIGHT &&
                bx >= SIDE_MARGIN && bx < SCREEN_WIDTH)
            begin
                brow = SCREEN_HEIGHT - 1 - ypos;
                addr = (TOP_MARGIN + brow) * ROW_STRIDE_BYTES +
                       (SIDE_MARGIN + bx) / 8 * 2;
                cap = (flen > FRAME_CAP) ? FRAME_CAP : flen;
                seg_open = 1;
                seg_live = (addr + 1 < cap);
                seg_addr = seg_live ? ADDR_W'(addr) : '0;
                seg_data = '0;
                seg_mask = '0;
            end
            if (seg_open)
            begin
                if (pix != 0 && seg_live)
                begin
                    shift = (7 - pos) * 2;
                    seg_data |= WORD_W'(ink) << shift;
                    seg_mask |= WORD_W'(3) << shift;
                end
                if (pos == 7 || col_end)
                begin
                    if (seg_live && seg_mask != 0)
                    begin
                        wr.addr = seg_addr;
                        wr.data = seg_data;
                        wr.mask = seg_mask;
                        wr.last = 1'b1;
                        wr.done = col_end && row_end;
                        due_writes.push_back(wr);
                    end
                    seg_open = 0;
                end
            end
            if (col_end)
            begin
                col = 0;
                row = row_end ? 0 : ((row + 1) & 'hFF);
            end
            else
                col = (col + 1) & 'hFF;
        endfunction

        function void check_write(fb_write_t got);
            fb_write_t want;
            if (due_writes.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("%0t: write with nothing due: addr=%h data=%h mask=%h",
                             $time, got.addr, got.data, got.mask);
                return;
            end
            want = due_writes.pop_front();
            if (got.addr !== want.addr || got.data !== want.data ||
                got.mask !== want.mask || got.last !== want.last ||
                got.done !== want.done)
            begin
                fails++;
                if (fails <= 10)
                begin
                    $display("%0t: write mismatch: expected addr=%h data=%h mask=%h last=%b done=%b",
                             $time, want.addr, want.data, want.mask, want.last, want.done);
                    $display("%0t:                 got      addr=%h data=%h mask=%h last=%b done=%b",
                             $time, got.addr, got.data, got.mask, got.last, got.done);
                end
            end
        endfunction

        function void close_out();
            if (due_writes.size() != 0)
            begin
                fails += due_writes.size();
                $display("%0d expected writes never arrived", due_writes.size());
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gbp_cfg_if cfg_ch();
    gbp_pix_if pix_ch();
    gbp_wr_if  wr_ch();

    glyph_blit_packed_2bpp_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .pixels (pix_ch),
        .writes (wr_ch)
    );

    word_write_board board = new();

    // Pacing knobs, retuned per phase by the stimulus
    int idle_max   = 0;   // longest gap between input bursts
    int stall_pct  = 0;   // chance per cycle that the write side starts a stall
    int stall_max  = 0;   // longest write-side stall
    int burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Write side: hold ready low for random stretches, otherwise accept
    initial
    begin : write_side
        int hold;
        hold = 0;
        wr_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                wr_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                hold = $urandom_range(0, stall_max);
                wr_ch.ready <= 1'b0;
            end
            else
                wr_ch.ready <= 1'b1;
        end
    end

    // Beat monitor: note accepted glyph bytes first, then check write beats
    always @(posedge clk)
    begin : beat_watch
        fb_write_t seen;
        if (rst_n)
        begin
            if (pix_ch.valid && pix_ch.ready)
                board.note_pixel(pix_ch.glyph_byte);
            if (wr_ch.valid && wr_ch.ready)
            begin
                seen.addr = wr_ch.word_address;
                seen.data = wr_ch.write_data;
                seen.mask = wr_ch.bit_mask;
                seen.last = wr_ch.last_in_run;
                seen.done = wr_ch.glyph_done;
                board.check_write(seen);
            end
        end
    end

    // Send one glyph byte; open a fresh burst after a random gap when due
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
            if (gap > 0)
            begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        pix_ch.valid <= 1'b1;
        pix_ch.glyph_byte <= value;
        do @(posedge clk); while (!pix_ch.ready);
    endtask

    // Send up to eight bytes, leftmost byte of the literal first
    task automatic send_bytes(input logic [63:0] bytes, input int n);
        for (int i = n - 1; i >= 0; i--)
            send_pixel(bytes[8*i +: 8]);
    endtask

    // Drop valid, wait for every due write, then let the pipe run dry
    task automatic settle();
        pix_ch.valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        while (board.due_writes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Hold valid high across the six back-to-back register beats
    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ch.ready);
        board.note_reg(idx, CFG_DATA_W'(value));
    endtask

    task automatic load_glyph_regs(input int x, input int y, input int w, input int h,
                                   input int ink, input int flen);
        write_reg(REG_X_ORG, x & 'h1FFF);
        write_reg(REG_Y_ORG, y & 'h1FFF);
        write_reg(REG_WIDTH, w & 'h1FF);
        write_reg(REG_HEIGHT, h & 'h1FF);
        write_reg(REG_INK, ink & 'h3);
        write_reg(REG_FLEN, flen & 'h7FFFFF);
        cfg_ch.valid <= 1'b0;
    endtask

    // Offsets: mostly inside the span, some straddling either edge,
    // a few anywhere in the 13-bit range
    function automatic int pick_offset(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return lo + $urandom_range(0, hi - lo);
        if (r < 8)
            return lo - 12 + $urandom_range(0, 20);
        if (r == 8)
            return hi - 8 + $urandom_range(0, 20);
        return int'($signed(13'($urandom)));
    endfunction

    initial
    begin : stimulus
        int x, y, w, h, ink, flen, weff, heff, glyph_len, beats, est;
        int random_sent, phase_no, guard;
        int sizes[5];

        sizes = '{0, 1, 256, 300, 511};
        random_sent = 0;
        phase_no = 0;

        // Every input known from time zero
        rst_n <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.glyph_byte <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_X_ORG;
        cfg_ch.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_max = 2;
        stall_pct = 20;
        stall_max = 4;

        // Reset settings: column 0 sits left of the margin, nothing drawn
        send_bytes(64'h00FF, 2);
        settle();

        // Segment opened just left of the right edge keeps drawing past it
        load_glyph_regs(SCREEN_WIDTH - 6, 0, 8, 1, 3, FRAME_CAP);
        send_bytes(64'hFF00_0180_FF00_FFFF, 8);
        settle();

        // Top screen row flips to buffer row 0; the row below falls off;
        // width 0 counts as 1, frame length above the cap is clamped
        load_glyph_regs(SIDE_MARGIN, SCREEN_HEIGHT - 1, 0, 2, 1, 'h7FFFFF);
        send_bytes(64'hFFFF, 2);
        settle();

        // Row above the screen skipped, rightmost column drawn, glyph closes
        load_glyph_regs(SCREEN_WIDTH - 1, -1, 1, 2, 2, FRAME_CAP);
        send_bytes(64'h8001, 2);
        settle();

        // Frame limit: word skipped when address + 1 reaches the length,
        // drawn one byte later
        est = (TOP_MARGIN + SCREEN_HEIGHT - 1) * ROW_STRIDE_BYTES + (2 * SIDE_MARGIN) / 8 * 2;
        load_glyph_regs(SIDE_MARGIN, 0, 2, 1, 3, est + 1);
        send_bytes(64'hFFFF, 2);
        settle();
        load_glyph_regs(SIDE_MARGIN, 0, 2, 1, 3, est + 2);
        send_bytes(64'hFFFF, 2);
        settle();

        // All-clear word gives no write; ink 0 still writes its mask
        load_glyph_regs(SIDE_MARGIN, 100, 3, 2, 0, FRAME_CAP);
        send_bytes(64'h0000_0000_4000, 6);
        settle();

        // Oversized glyph far off screen left part way through a row, then
        // shrink the width so the stale column ends the row and wraps
        load_glyph_regs(-4096, 4095, 511, 511, 0, 0);
        send_bytes(64'h5AA5, 2);
        settle();
        load_glyph_regs(SIDE_MARGIN, 10, 1, 1, 3, FRAME_CAP);
        send_bytes(64'hC3, 1);
        settle();

        // Random glyphs under changing settings and pacing
        while (random_sent < 700)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    w = sizes[$urandom_range(0, 4)];
                    h = $urandom_range(0, 2);
                end
                1:
                begin
                    w = $urandom_range(0, 2);
                    h = sizes[$urandom_range(0, 4)];
                end
                default:
                begin
                    w = $urandom_range(1, 20);
                    h = $urandom_range(1, 10);
                end
            endcase
            x = pick_offset(SIDE_MARGIN, SCREEN_WIDTH - 1);
            y = pick_offset(0, SCREEN_HEIGHT - 1);
            ink = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0:       flen = 'h7FFFFF;
                1:       flen = $urandom_range(0, 'h7FFFFF);
                2:
                begin
                    // land the limit somewhere across the glyph's rows
                    est = (TOP_MARGIN + SCREEN_HEIGHT - 1 - y) * ROW_STRIDE_BYTES +
                          (SIDE_MARGIN + x) / 8 * 2;
                    flen = est - 2 * ROW_STRIDE_BYTES + $urandom_range(0, 3 * ROW_STRIDE_BYTES);
                    if (flen < 0)
                        flen = 0;
                end
                default: flen = FRAME_CAP;
            endcase
            load_glyph_regs(x, y, w, h, ink, flen);

            weff = (w == 0) ? 1 : ((w > GLYPH_CAP) ? GLYPH_CAP : w);
            heff = (h == 0) ? 1 : ((h > GLYPH_CAP) ? GLYPH_CAP : h);
            glyph_len = weff * heff;
            // mostly whole glyphs; now and then stop part way through one
            if ($urandom_range(0, 99) < 15)
                beats = $urandom_range(1, glyph_len);
            else if (glyph_len > 64)
                beats = glyph_len;
            else
                beats = glyph_len * $urandom_range(1, 2);
            // keep the total close to the planned item count
            if (random_sent + beats > 700)
                beats = 700 - random_sent;

            case ($urandom_range(0, 3))
                0:       idle_max = 0;
                1:       idle_max = 3;
                default: idle_max = $urandom_range(0, 12);
            endcase
            case ($urandom_range(0, 3))
                0:
                begin
                    stall_pct = 0;
                    stall_max = 0;
                end
                1:
                begin
                    stall_pct = 50;
                    stall_max = 20;
                end
                default:
                begin
                    stall_pct = 20;
                    stall_max = 3;
                end
            endcase

            for (int i = 0; i < beats; i++)
            begin
                // once, hold the input until every write has drained
                if (phase_no == 0 && i == beats / 2)
                    settle();
                send_pixel(($urandom_range(0, 99) < 35) ? 8'h00 : 8'($urandom_range(1, 255)));
            end
            random_sent += beats;
            phase_no++;
            settle();
        end

        // Final drain with a bound, then a few cycles for stray writes
        pix_ch.valid <= 1'b0;
        guard = 0;
        while (board.due_writes.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        board.close_out();
        if (board.fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
